[rtl/scrs_pkg.sv]
// scrs_pkg: shared constants, codes and control structs of the sync capture ring store.
// Used by the top level, scrs_ctrl, scrs_dp, the checker and the bench; depends on nothing.
package scrs_pkg;

    // default geometry
    localparam int RING_SLOTS_DEF         = 255;
    localparam int SLOT_BYTES_DEF         = 144;
    localparam int MAX_RESPONSE_BYTES_DEF = 256;

    // sync sequence
    localparam logic [7:0]  SYNC_A    = 8'hAA;
    localparam logic [7:0]  SYNC_B    = 8'h44;
    localparam logic [7:0]  SYNC_C    = 8'h12;
    localparam logic [15:0] SYNC_HIST = {SYNC_A, SYNC_B};
    localparam int          SYNC_LEN  = 3;

    // item function codes
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_FAIL = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // configuration register index (byte address bit 2 selects the word)
    localparam logic REG_CAPTURE_ENABLE = 1'b0;

    // stream widths
    localparam int BYTE_W     = 8;
    localparam int FAIL_W     = 32;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 64;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // result layout in m_tdata
    localparam int M_COMMIT_BIT  = 0;
    localparam int M_MISSING_BIT = 1;
    localparam int M_RDATA_LSB   = 2;
    localparam int M_RVALID_BIT  = 10;
    localparam int M_WIDX_LSB    = 11;
    localparam int M_COUNT_LSB   = 19;
    localparam int M_FAIL_LSB    = 27;

    // controller to datapath
    typedef struct packed {
        logic take;        // scan / capture the item's byte
        logic end_resp;    // clear response tracking
        logic fail_inc;    // count one failure
        logic read;        // launch a ring read
        logic read_out;    // result carries the ring read
        logic copy_start;  // begin staging-to-ring copy
        logic copy_step;   // advance the copy
        logic commit;      // advance index and count
        logic missing;     // result flags a missing sync
        logic load_out;    // load the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cap_en;       // capture enable register
        logic will_capture; // a sync is held after the current byte
        logic copy_done;    // last slot byte is written this cycle
        logic out_free;     // result register can take a new result
    } dp_status_t;

endpackage

[rtl/sync_capture_ring_store.sv]
// sync_capture_ring_store: top level with the stream ports and the APB register port.
// Depends on scrs_pkg, scrs_ctrl, scrs_dp (and scrs_ram through scrs_dp).
//
// Usage
//   Feed one receiver response a byte at a time on the slave stream (func 0 in s_tuser,
//   s_tlast on the final byte). The block scans for the first AA 44 12, captures up to
//   SLOT_BYTES bytes from the sync on, and at the end of the response zero-pads and
//   commits them to the ring slot at the write index. func 1 reports a comms failure,
//   func 2 reads one stored byte. Every item gives exactly one result on the master
//   stream, carrying flags, read data and the ring status after the item.
// Timing
//   Byte, failure and unused-code items: result the cycle after accept, one item a cycle
//   unless the result stalls. Reads: the ring read is registered, then the result loads;
//   no item is taken while a read is pending. Closing byte with a sync: the staging slot
//   is copied into the ring one byte a cycle through the single ring write port, then the
//   result loads; no item is taken meanwhile.
// Reset
//   Clears counters, write index, sample count and response tracking; capture_enable
//   comes up set. The ring memory is not cleared: only committed slots are readable.
// Stalls
//   The result register holds its item while m_tready is low; one further item may be
//   taken only if the held result leaves in the same cycle, else s_tready stays low.
module sync_capture_ring_store #(
    parameter int RING_SLOTS         = scrs_pkg::RING_SLOTS_DEF,
    parameter int SLOT_BYTES         = scrs_pkg::SLOT_BYTES_DEF,
    parameter int MAX_RESPONSE_BYTES = scrs_pkg::MAX_RESPONSE_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scrs_pkg::S_TDATA_W-1:0]    s_tdata,  // data_byte, slot_index, byte_offset
    input  logic [scrs_pkg::S_TUSER_W-1:0]    s_tuser,  // func
    input  logic                              s_tlast,  // last_byte
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [scrs_pkg::M_TDATA_W-1:0]    m_tdata,  // commit_done, sync_missing,
                                                        // read_data, read_valid,
                                                        // write_index, sample_count,
                                                        // failure_count, zero pad
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scrs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [scrs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [scrs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    scrs_pkg::ctrl_cmd_t  cmd;
    scrs_pkg::dp_status_t st;
    logic                 reg_sel;
    logic                 cfg_we;

    // word select: bit 2 of the byte address picks the register
    assign reg_sel = (paddr[2] == scrs_pkg::REG_CAPTURE_ENABLE);
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? scrs_pkg::APB_DATA_W'(st.cap_en) : '0;

    scrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tuser),
        .last_byte (s_tlast),
        .st        (st),
        .cmd       (cmd)
    );

    scrs_dp #(
        .RING_SLOTS         (RING_SLOTS),
        .SLOT_BYTES         (SLOT_BYTES),
        .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (pwdata[0]),
        .data_byte   (s_tdata[7:0]),
        .slot_index  (s_tdata[15:8]),
        .byte_offset (s_tdata[23:16]),
        .cmd         (cmd),
        .st          (st),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

[rtl/scrs_ram.sv]
// scrs_ram: generic single-write, single-read RAM with registered read data.
// Used for the staging slot and the ring store; depends on nothing.
module scrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/scrs_ctrl.sv]
// scrs_ctrl: item sequencer of the sync capture ring store (accept, read wait, slot copy).
// Depends on scrs_pkg; drives commands into scrs_dp and reads its status.
module scrs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             func,
    input  logic                   last_byte,
    input  scrs_pkg::dp_status_t   st,
    output scrs_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE) && st.out_free;
        accept     = s_tvalid && s_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        scrs_pkg::FUNC_BYTE:
                        begin
                            if (st.cap_en)
                            begin
                                cmd.take = 1'b1;
                                if (last_byte && st.will_capture)
                                begin
                                    cmd.copy_start = 1'b1;
                                    state_next     = ST_COPY;
                                end
                                else if (last_byte)
                                begin
                                    cmd.fail_inc = 1'b1;
                                    cmd.end_resp = 1'b1;
                                    cmd.missing  = 1'b1;
                                    cmd.load_out = 1'b1;
                                end
                                else
                                begin
                                    cmd.load_out = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.load_out = 1'b1;
                            end
                        end
                        scrs_pkg::FUNC_FAIL:
                        begin
                            cmd.fail_inc = st.cap_en;
                            cmd.end_resp = st.cap_en;
                            cmd.load_out = 1'b1;
                        end
                        scrs_pkg::FUNC_READ:
                        begin
                            cmd.read   = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            cmd.load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.read_out = 1'b1;
                cmd.load_out = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (st.copy_done)
                begin
                    cmd.commit   = 1'b1;
                    cmd.end_resp = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/scrs_dp.sv]
// scrs_dp: datapath of the sync capture ring store: sync scan, staging slot, ring store,
// counters and the result register. Depends on scrs_pkg and scrs_ram.
module scrs_dp #(
    parameter int RING_SLOTS         = scrs_pkg::RING_SLOTS_DEF,
    parameter int SLOT_BYTES         = scrs_pkg::SLOT_BYTES_DEF,
    parameter int MAX_RESPONSE_BYTES = scrs_pkg::MAX_RESPONSE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic [scrs_pkg::BYTE_W-1:0]     data_byte,
    input  logic [scrs_pkg::BYTE_W-1:0]     slot_index,
    input  logic [scrs_pkg::BYTE_W-1:0]     byte_offset,
    input  scrs_pkg::ctrl_cmd_t             cmd,
    output scrs_pkg::dp_status_t            st,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [scrs_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int POS_W  = $clog2(MAX_RESPONSE_BYTES + 1);
    localparam int OFF_W  = $clog2(SLOT_BYTES + 1);
    localparam int SIDX_W = $clog2(SLOT_BYTES);
    localparam int IDX_W  = $clog2(RING_SLOTS);
    localparam int CNT_W  = $clog2(RING_SLOTS + 1);
    localparam int AW     = $clog2(RING_SLOTS * SLOT_BYTES);
    localparam int CMP_W  = (CNT_W > scrs_pkg::BYTE_W) ? CNT_W : scrs_pkg::BYTE_W;
    localparam int PAD_W  = scrs_pkg::M_TDATA_W - scrs_pkg::M_FAIL_LSB - scrs_pkg::FAIL_W;

    // response tracking
    logic                        cap_en_reg, cap_en_next;
    logic [15:0]                 hist_reg, hist_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic                        act_reg, act_next;
    logic [OFF_W-1:0]            off_reg, off_next;
    // ring status
    logic [IDX_W-1:0]            widx_reg, widx_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [AW-1:0]               base_reg, base_next;
    logic [scrs_pkg::FAIL_W-1:0] fail_reg, fail_next;
    // copy sequencer
    logic [SIDX_W-1:0]           crd_idx_reg, crd_idx_next;
    logic                        crd_more_reg, crd_more_next;
    logic                        cwr_pend_reg, cwr_pend_next;
    logic [SIDX_W-1:0]           cwr_idx_reg;
    // read flags and result
    logic                        rd_valid_reg;
    logic                        rd_offs_ok_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [scrs_pkg::M_TDATA_W-1:0] out_data_reg;

    logic                        take_ok;
    logic                        sync_hit;
    logic                        stage_we;
    logic [scrs_pkg::BYTE_W-1:0] stage_q;
    logic [scrs_pkg::BYTE_W-1:0] ring_q;
    logic [scrs_pkg::BYTE_W-1:0] ring_wdata;
    logic [AW-1:0]               ring_waddr;
    logic [AW-1:0]               ring_raddr;
    logic                        slot_ok;
    logic                        offs_ok;
    logic                        res_rvalid;
    logic [scrs_pkg::BYTE_W-1:0] res_rdata;

    assign take_ok  = pos_reg < POS_W'(MAX_RESPONSE_BYTES);
    assign sync_hit = !act_reg && (pos_reg >= POS_W'(2)) &&
                      (hist_reg == scrs_pkg::SYNC_HIST) && (data_byte == scrs_pkg::SYNC_C);

    // scan, capture and end of response
    always_comb
    begin
        hist_next = hist_reg;
        pos_next  = pos_reg;
        act_next  = act_reg;
        off_next  = off_reg;
        stage_we  = 1'b0;
        if (cmd.take && take_ok)
        begin
            if (act_reg)
            begin
                if (off_reg < OFF_W'(SLOT_BYTES))
                begin
                    stage_we = 1'b1;
                    off_next = off_reg + OFF_W'(1);
                end
            end
            else if (sync_hit)
            begin
                off_next = OFF_W'(scrs_pkg::SYNC_LEN);
                act_next = 1'b1;
            end
            hist_next = {hist_reg[7:0], data_byte};
            pos_next  = pos_reg + POS_W'(1);
        end
        if (cmd.end_resp)
        begin
            hist_next = '0;
            pos_next  = '0;
            act_next  = 1'b0;
            off_next  = '0;
        end
    end

    // ring index, count, failures, configuration
    always_comb
    begin
        widx_next   = widx_reg;
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        fail_next   = fail_reg;
        cap_en_next = cap_en_reg;
        if (cmd.commit)
        begin
            if (widx_reg == IDX_W'(RING_SLOTS - 1))
            begin
                widx_next = '0;
                base_next = '0;
            end
            else
            begin
                widx_next = widx_reg + IDX_W'(1);
                base_next = base_reg + AW'(SLOT_BYTES);
            end
            if (cnt_reg < CNT_W'(RING_SLOTS))
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.fail_inc)
        begin
            fail_next = fail_reg + scrs_pkg::FAIL_W'(1);
        end
        if (cfg_we)
        begin
            cap_en_next = cfg_wdata;
        end
    end

    // copy: read staging at crd_idx, write ring in the cycle after
    always_comb
    begin
        crd_idx_next  = crd_idx_reg;
        crd_more_next = crd_more_reg;
        cwr_pend_next = cwr_pend_reg;
        if (cmd.copy_start)
        begin
            crd_idx_next  = '0;
            crd_more_next = 1'b1;
            cwr_pend_next = 1'b0;
        end
        else if (cmd.copy_step)
        begin
            cwr_pend_next = crd_more_reg;
            if (crd_more_reg)
            begin
                if (crd_idx_reg == SIDX_W'(SLOT_BYTES - 1))
                begin
                    crd_more_next = 1'b0;
                end
                else
                begin
                    crd_idx_next = crd_idx_reg + SIDX_W'(1);
                end
            end
        end
    end

    // sync bytes are constants, bytes past the captured length pad with zero
    always_comb
    begin
        if (cwr_idx_reg == SIDX_W'(0))
        begin
            ring_wdata = scrs_pkg::SYNC_A;
        end
        else if (cwr_idx_reg == SIDX_W'(1))
        begin
            ring_wdata = scrs_pkg::SYNC_B;
        end
        else if (cwr_idx_reg == SIDX_W'(2))
        begin
            ring_wdata = scrs_pkg::SYNC_C;
        end
        else if (OFF_W'(cwr_idx_reg) < off_reg)
        begin
            ring_wdata = stage_q;
        end
        else
        begin
            ring_wdata = '0;
        end
    end

    assign ring_waddr = base_reg + AW'(cwr_idx_reg);
    assign ring_raddr = AW'(slot_index) * AW'(SLOT_BYTES) + AW'(byte_offset);
    assign slot_ok    = CMP_W'(slot_index) < CMP_W'(cnt_reg);
    assign offs_ok    = {1'b0, byte_offset} < 9'(SLOT_BYTES);

    scrs_ram #(
        .WIDTH (scrs_pkg::BYTE_W),
        .DEPTH (SLOT_BYTES)
    ) u_stage (
        .clk   (clk),
        .we    (stage_we),
        .waddr (off_reg[SIDX_W-1:0]),
        .wdata (data_byte),
        .raddr (crd_idx_reg),
        .rdata (stage_q)
    );

    scrs_ram #(
        .WIDTH (scrs_pkg::BYTE_W),
        .DEPTH (RING_SLOTS * SLOT_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (cwr_pend_reg),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_q)
    );

    // result register
    assign res_rvalid = cmd.read_out && rd_valid_reg;
    assign res_rdata  = (res_rvalid && rd_offs_ok_reg) ? ring_q : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_en_reg    <= 1'b1;
            hist_reg      <= '0;
            pos_reg       <= '0;
            act_reg       <= 1'b0;
            off_reg       <= '0;
            widx_reg      <= '0;
            cnt_reg       <= '0;
            base_reg      <= '0;
            fail_reg      <= '0;
            crd_idx_reg   <= '0;
            crd_more_reg  <= 1'b0;
            cwr_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_en_reg    <= cap_en_next;
            hist_reg      <= hist_next;
            pos_reg       <= pos_next;
            act_reg       <= act_next;
            off_reg       <= off_next;
            widx_reg      <= widx_next;
            cnt_reg       <= cnt_next;
            base_reg      <= base_next;
            fail_reg      <= fail_next;
            crd_idx_reg   <= crd_idx_next;
            crd_more_reg  <= crd_more_next;
            cwr_pend_reg  <= cwr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cwr_idx_reg <= crd_idx_reg;
        if (cmd.read)
        begin
            rd_valid_reg   <= slot_ok;
            rd_offs_ok_reg <= offs_ok;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, fail_next,
                             scrs_pkg::BYTE_W'(cnt_next), scrs_pkg::BYTE_W'(widx_next),
                             res_rvalid, res_rdata, cmd.missing, cmd.commit};
        end
    end

    assign st.cap_en       = cap_en_reg;
    assign st.will_capture = act_reg || (take_ok && sync_hit);
    assign st.copy_done    = cwr_pend_reg && (cwr_idx_reg == SIDX_W'(SLOT_BYTES - 1));
    assign st.out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/scrs_checker.sv]
// scrs_checker: port-level assertions of the sync capture ring store, bound to the top level.
// Depends on scrs_pkg and sync_capture_ring_store.
module scrs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [scrs_pkg::M_TDATA_W-1:0] m_tdata
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a response ends either committed or as missing sync, never both
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[scrs_pkg::M_COMMIT_BIT] && m_tdata[scrs_pkg::M_MISSING_BIT]))
        else $error("commit and missing sync in one result");

    // an invalid read returns zero data
    a_rdzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[scrs_pkg::M_RVALID_BIT]
        |-> m_tdata[scrs_pkg::M_RDATA_LSB +: scrs_pkg::BYTE_W] == '0)
        else $error("read data without a valid slot");

    // a commit leaves at least one stored sample
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[scrs_pkg::M_COMMIT_BIT]
        |-> m_tdata[scrs_pkg::M_COUNT_LSB +: scrs_pkg::BYTE_W] != '0)
        else $error("commit with an empty ring");

endmodule

bind sync_capture_ring_store scrs_checker u_scrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tb.sv]
// tb: self-checking bench for sync_capture_ring_store. Streams response, failure, read and
// spare-code items, toggles capture_enable over APB and checks every result in order.
// Depends on scrs_pkg and the sync_capture_ring_store RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scrs_pkg::*;

    localparam int SLOTS       = RING_SLOTS_DEF;
    localparam int SLOT_SIZE   = SLOT_BYTES_DEF;
    localparam int RESP_LIMIT  = MAX_RESPONSE_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_AT     = 300;   // items taken before the long receiver hold-off
    localparam int HOLD_CYCLES = 400;

    // func code 3 has no meaning in the block
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_CAPTURE_ENABLE = {REG_CAPTURE_ENABLE, 2'b00};

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data;
        logic       last;
        logic [7:0] slot;
        logic [7:0] offs;
    } link_item_t;

    typedef struct packed {
        logic        commit;
        logic        missing;
        logic [7:0]  rdata;
        logic        rvalid;
        logic [7:0]  widx;
        logic [7:0]  count;
        logic [31:0] fails;
    } ring_status_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // data_byte, slot_index, byte_offset
    logic [S_TUSER_W-1:0]  s_tuser;   // func
    logic                  s_tlast;   // last_byte
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // commit_done, sync_missing, read_data, read_valid,
                                      // write_index, sample_count, failure_count, zero pad
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sync_capture_ring_store dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Capture predictor: its own copy of the register, the response
    // tracking, the staging slot and the ring.
    // ------------------------------------------------------------------
    logic        cap_en     = 1'b1;
    logic [15:0] sync_hist  = '0;
    logic [8:0]  resp_len   = '0;
    logic        capturing  = 1'b0;
    logic [7:0]  stage_fill = '0;
    logic [7:0]  next_slot  = '0;
    logic [7:0]  slots_held = '0;
    logic [31:0] fail_total = '0;
    logic [7:0]  stage [SLOT_SIZE];
    logic [7:0]  ring_bytes [SLOTS*SLOT_SIZE];   // entries stay unknown until committed

    link_item_t   link_items [$];   // items waiting to be offered
    ring_status_t due_status [$];   // predicted results, oldest first
    int           queued      = 0;
    int           items_taken = 0;
    int           mismatches  = 0;
    int           cycles      = 0;

    // Forget the current response: history, position and staging all restart.
    function automatic void drop_response();
        sync_hist  = '0;
        resp_len   = '0;
        capturing  = 1'b0;
        stage_fill = '0;
    endfunction

    // Advance the predicted state by one accepted item and return its result.
    function automatic ring_status_t capture_step(input link_item_t it);
        ring_status_t r;
        int           i;
        r = '0;
        if (it.func == FUNC_BYTE && cap_en)
        begin
            // bytes past the response limit are neither scanned nor captured
            if (resp_len < 9'(RESP_LIMIT))
            begin
                if (capturing)
                begin
                    if (stage_fill < 8'(SLOT_SIZE))
                    begin
                        stage[stage_fill] = it.data;
                        stage_fill++;
                    end
                end
                else if (resp_len >= 9'd2 && sync_hist == SYNC_HIST && it.data == SYNC_C)
                begin
                    for (i = 0; i < SLOT_SIZE; i++)
                        stage[8'(i)] = 8'h00;
                    stage[0]   = SYNC_A;
                    stage[1]   = SYNC_B;
                    stage[2]   = SYNC_C;
                    stage_fill = 8'(SYNC_LEN);
                    capturing  = 1'b1;
                end
                sync_hist = {sync_hist[7:0], it.data};
                resp_len++;
            end
            if (it.last)
            begin
                if (capturing)
                begin
                    for (i = 0; i < SLOT_SIZE; i++)
                        ring_bytes[16'(next_slot*SLOT_SIZE + i)] = stage[8'(i)];
                    next_slot = (next_slot == 8'(SLOTS - 1)) ? 8'd0 : next_slot + 8'd1;
                    if (slots_held < 8'(SLOTS))
                        slots_held++;
                    r.commit = 1'b1;
                end
                else
                begin
                    fail_total++;
                    r.missing = 1'b1;
                end
                drop_response();
            end
        end
        else if (it.func == FUNC_FAIL && cap_en)
        begin
            fail_total++;
            drop_response();
        end
        else if (it.func == FUNC_READ)
        begin
            if (it.slot < slots_held)
            begin
                r.rvalid = 1'b1;
                if (it.offs < 8'(SLOT_SIZE))
                    r.rdata = ring_bytes[16'(it.slot*SLOT_SIZE + it.offs)];
            end
        end
        r.widx  = next_slot;
        r.count = slots_held;
        r.fails = fail_total;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
    endtask

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: offer queued items in bursts of random length with random
    // gaps. A held item stays on the bus untouched until it is taken; the
    // prediction is made at the edge that takes it.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                due_status.push_back(capture_step(link_items[0]));
                void'(link_items.pop_front());
                items_taken <= items_taken + 1;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (link_items.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= link_items[0].func;
                    s_tlast  <= link_items[0].last;
                    s_tdata  <= {link_items[0].offs, link_items[0].slot, link_items[0].data};
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // a third of the bursts run straight into the next one
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a stall pattern of its own, switching mode now and then.
    // The long hold-off is counted in its own process and fires once, in
    // the middle of a busy phase, so the block backs up and drops s_tready.
    // ------------------------------------------------------------------
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    rx_mode_t rx_mode   = RX_OPEN;
    int       mode_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (!hold_done && items_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 120);
            end
            else
            begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   m_tready <= (hold_left == 0);
                RX_COIN:   m_tready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_tready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
                default:   m_tready <= (hold_left == 0) && (mode_left % 8 < 5);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        ring_status_t want;
        ring_status_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.commit  = m_tdata[M_COMMIT_BIT];
            got.missing = m_tdata[M_MISSING_BIT];
            got.rdata   = m_tdata[M_RDATA_LSB +: 8];
            got.rvalid  = m_tdata[M_RVALID_BIT];
            got.widx    = m_tdata[M_WIDX_LSB +: 8];
            got.count   = m_tdata[M_COUNT_LSB +: 8];
            got.fails   = m_tdata[M_FAIL_LSB +: 32];
            if (due_status.size() == 0)
            begin
                report_mismatch("result with nothing expected", m_tdata[31:0], 32'd0);
            end
            else
            begin
                want = due_status.pop_front();
                if (got.commit !== want.commit)
                    report_mismatch("commit_done", got.commit, want.commit);
                if (got.missing !== want.missing)
                    report_mismatch("sync_missing", got.missing, want.missing);
                if (got.rdata !== want.rdata)
                    report_mismatch("read_data", got.rdata, want.rdata);
                if (got.rvalid !== want.rvalid)
                    report_mismatch("read_valid", got.rvalid, want.rvalid);
                if (got.widx !== want.widx)
                    report_mismatch("write_index", got.widx, want.widx);
                if (got.count !== want.count)
                    report_mismatch("sample_count", got.count, want.count);
                if (got.fails !== want.fails)
                    report_mismatch("failure_count", got.fails, want.fails);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [1:0] func, input logic [7:0] data,
                              input logic last, input logic [7:0] slot,
                              input logic [7:0] offs);
        link_item_t it;
        it.func = func;
        it.data = data;
        it.last = last;
        it.slot = slot;
        it.offs = offs;
        link_items.push_back(it);
        queued++;
    endtask

    // Fields a function code does not use carry random junk.
    task automatic queue_byte(input logic [7:0] data, input logic last);
        queue_item(FUNC_BYTE, data, last, 8'($urandom), 8'($urandom));
    endtask

    task automatic queue_read(input logic [7:0] slot, input logic [7:0] offs);
        queue_item(FUNC_READ, 8'($urandom), 1'($urandom), slot, offs);
    endtask

    task automatic queue_other(input logic [1:0] func);
        queue_item(func, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Bias toward sync bytes so partial and broken syncs show up often.
    function automatic logic [7:0] noisy_byte();
        case ($urandom_range(0, 5))
            0:       return SYNC_A;
            1:       return SYNC_B;
            2:       return SYNC_C;
            default: return 8'($urandom);
        endcase
    endfunction

    // Queue len response bytes with a sync at sync_at (negative: none). With
    // closed clear the response is left open.
    task automatic queue_response(input int len, input int sync_at, input bit closed);
        int         i;
        logic [7:0] b;
        for (i = 0; i < len; i++)
        begin
            if (sync_at >= 0 && i == sync_at)
                b = SYNC_A;
            else if (sync_at >= 0 && i == sync_at + 1)
                b = SYNC_B;
            else if (sync_at >= 0 && i == sync_at + 2)
                b = SYNC_C;
            else
                b = noisy_byte();
            queue_byte(b, closed && (i == len - 1));
        end
    endtask

    // Mostly reads of committed slots, the rest anywhere in the slot range.
    task automatic queue_random_read();
        logic [7:0] slot;
        logic [7:0] offs;
        if (slots_held != 0 && $urandom_range(0, 3) != 0)
            slot = 8'($urandom_range(0, slots_held - 1));
        else
            slot = 8'($urandom_range(0, SLOTS - 1));
        offs = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, SLOT_SIZE - 1));
        queue_read(slot, offs);
    endtask

    // Random mix of well-formed responses, broken ones and other items. A fill
    // phase sends near-minimal synced responses and reads to cycle the ring.
    task automatic queue_random_phase(input int n, input bit fill);
        int stop;
        int pick;
        int len;
        stop = queued + n;
        while (queued < stop)
        begin
            pick = $urandom_range(0, 99);
            if (fill)
                pick = (pick < 85) ? 0 : 70;
            if (pick < 45)
            begin
                len = fill ? $urandom_range(3, 4) : $urandom_range(3, 8);
                queue_response(len, $urandom_range(0, len - 3), 1'b1);
            end
            else if (pick < 57)
            begin
                queue_response($urandom_range(1, 10), -1, 1'b1);
            end
            else if (pick < 66)
            begin
                len = $urandom_range(10, 60);
                queue_response(len, $urandom_range(0, len - 3), 1'b1);
            end
            else if (pick < 68)
            begin
                // long response: sync early overflows the slot, sync late may pass the limit unseen
                len = $urandom_range(260, 300);
                queue_response(len, ($urandom_range(0, 3) == 0) ? $urandom_range(250, len - 3)
                                                                : $urandom_range(0, 30), 1'b1);
            end
            else if (pick < 80)
            begin
                queue_random_read();
            end
            else if (pick < 88)
            begin
                // failure event, half the time in the middle of a response
                if ($urandom_range(0, 1) == 1)
                begin
                    len = $urandom_range(3, 12);
                    queue_response(len, $urandom_range(0, len - 3), 1'b0);
                end
                queue_other(FUNC_FAIL);
            end
            else if (pick < 92)
            begin
                queue_other(FUNC_SPARE);
            end
            else
            begin
                // reads in the middle of a response must not disturb it
                queue_response(4, 0, 1'b0);
                queue_random_read();
                queue_response($urandom_range(1, 5), -1, 1'b1);
            end
        end
    endtask

    // Hold until everything queued has been taken and every result is back.
    task automatic wait_idle();
        while (link_items.size() != 0 || s_tvalid || due_status.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register loads at the
    // edge that closes the access cycle.
    task automatic write_capture_enable(input logic value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPTURE_ENABLE;
        pwdata  <= {{(APB_DATA_W-1){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_en = value;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_capture_enable(1'b1);

        // read of an empty ring
        queue_read(8'd0, 8'd0);
        // short responses: one byte, then two sync bytes without the third
        queue_byte(SYNC_A, 1'b1);
        queue_byte(SYNC_A, 1'b0);
        queue_byte(SYNC_B, 1'b1);
        // sync after one leading byte, data extremes, commit to slot 0
        queue_byte(8'h00, 1'b0);
        queue_response(3, 0, 1'b0);
        queue_byte(8'h5A, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // sync byte, captured data, padding, offset past the slot, far offset
        queue_read(8'd0, 8'd0);
        queue_read(8'd0, 8'd4);
        queue_read(8'd0, 8'(SLOT_SIZE - 1));
        queue_read(8'd0, 8'(SLOT_SIZE));
        queue_read(8'd0, 8'hFF);
        queue_read(8'd1, 8'd0);
        // second sync inside a capture is plain data
        queue_response(3, 0, 1'b0);
        queue_response(3, 0, 1'b1);
        queue_read(8'd1, 8'd3);
        // failure abandons a capture in progress; spare code changes nothing
        queue_response(4, 0, 1'b0);
        queue_other(FUNC_FAIL);
        queue_other(FUNC_SPARE);
        queue_read(8'(SLOTS - 1), 8'(SLOT_SIZE - 1));
        wait_idle();

        // capture disabled in the middle of a response; it resumes afterwards
        queue_response(6, 1, 1'b0);
        wait_idle();
        write_capture_enable(1'b0);
        queue_random_phase(60, 1'b0);
        wait_idle();
        write_capture_enable(1'b1);
        queue_response(4, -1, 1'b1);
        queue_read(8'd2, 8'd0);
        wait_idle();

        // main mix; the long receiver hold-off lands in here
        queue_response(300, 5, 1'b1);
        queue_random_phase(100, 1'b0);
        wait_idle();
        write_capture_enable(1'b0);
        queue_random_phase(50, 1'b0);
        wait_idle();
        write_capture_enable(1'b1);
        queue_random_phase(100, 1'b0);
        wait_idle();

        // cycle the ring past capacity so the index wraps and the count saturates
        queue_random_phase(1000, 1'b1);
        wait_idle();

        // any stray result shows up in this quiet stretch
        repeat (SLOT_SIZE + 16) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
